@@ hw/rtl/pip_pkg.sv @@
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 16;
    localparam int TOL_WIDTH    = 32;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int VERT_W = 2 * COORD_WIDTH;

    // coordinate differences, their products and the tolerance sums
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = ((PROD_W > TOL_WIDTH + 1) ? PROD_W : TOL_WIDTH + 1) + 2;

    // offset of the query x from the edge start plus tolerance
    localparam int DOFF_W = ((DIFF_W > TOL_WIDTH) ? DIFF_W : TOL_WIDTH) + 2;

    // shared multiplier operands and product
    localparam int MUL_A_W = (DIFF_W > TOL_WIDTH) ? DIFF_W : TOL_WIDTH;
    localparam int MUL_B_W = DIFF_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [DOFF_W-1:0] DOFF_SPAN =
        {{(DOFF_W - TOL_WIDTH){1'b0}}, 1'b1, {(TOL_WIDTH - 1){1'b0}}};

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
    localparam logic [1:0] LOC_BOUNDARY = 2'd1;
    localparam logic [1:0] LOC_INSIDE   = 2'd2;

endpackage

@@ hw/rtl/pip_ram.sv @@
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/point_in_polygon_classify.sv @@
// clear and append finish from idle; an append result strobes on the cycle after the transfer
// a query walks the stored edges on one shared multiplier: each vertex is read from
// the vertex ram (fetch, latch), then each edge runs diff, the multiply states and eval
// a query on an empty polygon answers without a walk, a boundary contact ends the walk early
// busy is high while a query runs; the receiver cannot stall, results are never held
// rst_n clears tolerance, vertex count and dropped flag; the vertex ram is not cleared
module point_in_polygon_classify
    import pip_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic                          tolerance_we,
    input  logic [TOL_WIDTH-1:0]          tolerance,
    output logic                          done,
    output logic [1:0]                    location,
    output logic                          overflow
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_LATCH,
        S_DIFF,
        S_MUL_EXQY,
        S_MUL_EYQX,
        S_MUL_QXEX,
        S_MUL_QYEY,
        S_MUL_EXEX,
        S_MUL_EYEY,
        S_MUL_DADY,
        S_EVAL
    } state_t;

    state_t state_reg, state_next;

    logic [TOL_WIDTH-1:0] tol_reg, tol_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 last_reg, last_next;
    logic                 parity_reg, parity_next;

    logic signed [COORD_WIDTH-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_WIDTH-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_WIDTH-1:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [COORD_WIDTH-1:0] fx_reg, fx_next, fy_reg, fy_next;

    logic signed [DIFF_W-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic signed [DIFF_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [DIFF_W-1:0] ady_reg, ady_next;
    logic signed [DOFF_W-1:0] doff_reg, doff_next;
    logic                     straddle_reg, straddle_next;
    logic                     dpos_reg, dpos_next;

    logic signed [MUL_P_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]   cross_reg, cross_next;
    logic signed [ACC_W-1:0]   dot_reg, dot_next;
    logic signed [ACC_W-1:0]   len_reg, len_next;
    logic signed [ACC_W-1:0]   num_reg, num_next;

    logic       done_reg, done_next;
    logic [1:0] location_reg, location_next;
    logic       overflow_reg, overflow_next;

    logic                      ram_we;
    logic [VERT_W-1:0]         ram_rdata;
    logic signed [COORD_WIDTH-1:0] rd_x, rd_y;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    logic signed [DIFF_W-1:0]  dy;
    logic signed [ACC_W-1:0]   eps;
    logic signed [ACC_W-1:0]   snum;
    logic                      touch;
    logic                      flip;
    logic                      at_last;

    assign rd_x = signed'(ram_rdata[VERT_W-1:COORD_WIDTH]);
    assign rd_y = signed'(ram_rdata[COORD_WIDTH-1:0]);

    assign ram_we = (state_reg == S_IDLE) && start && (action == ACT_APPEND)
                    && (count_reg < CNT_W'(MAX_VERTICES));

    pip_ram #(
        .WIDTH(VERT_W),
        .DEPTH(MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({coord_x, coord_y}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_EXQY:
            begin
                mul_a = MUL_A_W'(ex_reg);
                mul_b = qy_reg;
            end
            S_MUL_EYQX:
            begin
                mul_a = MUL_A_W'(ey_reg);
                mul_b = qx_reg;
            end
            S_MUL_QXEX:
            begin
                mul_a = MUL_A_W'(qx_reg);
                mul_b = ex_reg;
            end
            S_MUL_QYEY:
            begin
                mul_a = MUL_A_W'(qy_reg);
                mul_b = ey_reg;
            end
            S_MUL_EXEX:
            begin
                mul_a = MUL_A_W'(ex_reg);
                mul_b = ex_reg;
            end
            S_MUL_EYEY:
            begin
                mul_a = MUL_A_W'(ey_reg);
                mul_b = ey_reg;
            end
            S_MUL_DADY:
            begin
                mul_a = signed'(doff_reg[MUL_A_W-1:0]);
                mul_b = ady_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign dy    = DIFF_W'(by_reg) - DIFF_W'(ay_reg);
    assign eps   = ACC_W'(signed'({1'b0, tol_reg}));
    assign snum  = dpos_reg ? num_reg : -num_reg;
    assign touch = (cross_reg <= eps) && (cross_reg >= -eps)
                   && (dot_reg >= -eps) && (dot_reg <= len_reg + eps);
    assign flip  = straddle_reg && (doff_reg < DOFF_SPAN)
                   && (prod_reg < MUL_P_W'(snum));
    assign at_last = ({1'b0, idx_reg} == count_reg - CNT_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        tol_next      = tol_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        parity_next   = parity_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        ady_next      = ady_reg;
        doff_next     = doff_reg;
        straddle_next = straddle_reg;
        dpos_next     = dpos_reg;
        prod_next     = mul_a * mul_b;
        cross_next    = cross_reg;
        dot_next      = dot_reg;
        len_next      = len_reg;
        num_next      = num_reg;
        done_next     = 1'b0;
        location_next = location_reg;
        overflow_next = overflow_reg;

        if (tolerance_we)
        begin
            tol_next = tolerance;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_CLEAR:
                        begin
                            count_next   = '0;
                            dropped_next = 1'b0;
                        end
                        ACT_APPEND:
                        begin
                            done_next     = 1'b1;
                            location_next = LOC_OUTSIDE;
                            if (count_reg < CNT_W'(MAX_VERTICES))
                            begin
                                count_next    = count_reg + CNT_W'(1);
                                overflow_next = 1'b0;
                            end
                            else
                            begin
                                dropped_next  = 1'b1;
                                overflow_next = 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            overflow_next = dropped_reg;
                            if (count_reg == '0)
                            begin
                                done_next     = 1'b1;
                                location_next = LOC_OUTSIDE;
                            end
                            else
                            begin
                                px_next     = coord_x;
                                py_next     = coord_y;
                                idx_next    = '0;
                                parity_next = 1'b0;
                                last_next   = 1'b0;
                                state_next  = S_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                if (idx_reg == '0)
                begin
                    fx_next = rd_x;
                    fy_next = rd_y;
                    ax_next = rd_x;
                    ay_next = rd_y;
                    if (count_reg == CNT_W'(1))
                    begin
                        bx_next    = rd_x;
                        by_next    = rd_y;
                        last_next  = 1'b1;
                        state_next = S_DIFF;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
                else
                begin
                    bx_next    = rd_x;
                    by_next    = rd_y;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                ex_next       = DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
                ey_next       = dy;
                qx_next       = DIFF_W'(px_reg) - DIFF_W'(ax_reg);
                qy_next       = DIFF_W'(py_reg) - DIFF_W'(ay_reg);
                ady_next      = (dy < 0) ? -dy : dy;
                dpos_next     = dy > 0;
                straddle_next = (by_reg > py_reg) != (ay_reg > py_reg);
                doff_next     = DOFF_W'(px_reg) - DOFF_W'(ax_reg)
                                + DOFF_W'(signed'({1'b0, tol_reg}));
                state_next    = S_MUL_EXQY;
            end
            S_MUL_EXQY:
            begin
                state_next = S_MUL_EYQX;
            end
            S_MUL_EYQX:
            begin
                cross_next = ACC_W'(prod_reg);
                num_next   = ACC_W'(prod_reg);
                state_next = S_MUL_QXEX;
            end
            S_MUL_QXEX:
            begin
                cross_next = cross_reg - ACC_W'(prod_reg);
                state_next = S_MUL_QYEY;
            end
            S_MUL_QYEY:
            begin
                dot_next   = ACC_W'(prod_reg);
                state_next = S_MUL_EXEX;
            end
            S_MUL_EXEX:
            begin
                dot_next   = dot_reg + ACC_W'(prod_reg);
                state_next = S_MUL_EYEY;
            end
            S_MUL_EYEY:
            begin
                len_next   = ACC_W'(prod_reg);
                state_next = S_MUL_DADY;
            end
            S_MUL_DADY:
            begin
                len_next   = len_reg + ACC_W'(prod_reg);
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (touch)
                begin
                    done_next     = 1'b1;
                    location_next = LOC_BOUNDARY;
                    state_next    = S_IDLE;
                end
                else if (last_reg)
                begin
                    done_next     = 1'b1;
                    location_next = (parity_reg ^ flip) ? LOC_INSIDE : LOC_OUTSIDE;
                    state_next    = S_IDLE;
                end
                else
                begin
                    parity_next = parity_reg ^ flip;
                    ax_next     = bx_reg;
                    ay_next     = by_reg;
                    if (at_last)
                    begin
                        // closing edge back to the first vertex
                        bx_next    = fx_reg;
                        by_next    = fy_reg;
                        last_next  = 1'b1;
                        state_next = S_DIFF;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tol_reg      <= '0;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            idx_reg      <= '0;
            last_reg     <= 1'b0;
            parity_reg   <= 1'b0;
            px_reg       <= '0;
            py_reg       <= '0;
            ax_reg       <= '0;
            ay_reg       <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
            fx_reg       <= '0;
            fy_reg       <= '0;
            ex_reg       <= '0;
            ey_reg       <= '0;
            qx_reg       <= '0;
            qy_reg       <= '0;
            ady_reg      <= '0;
            doff_reg     <= '0;
            straddle_reg <= 1'b0;
            dpos_reg     <= 1'b0;
            prod_reg     <= '0;
            cross_reg    <= '0;
            dot_reg      <= '0;
            len_reg      <= '0;
            num_reg      <= '0;
            done_reg     <= 1'b0;
            location_reg <= LOC_OUTSIDE;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tol_reg      <= tol_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
            parity_reg   <= parity_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            ax_reg       <= ax_next;
            ay_reg       <= ay_next;
            bx_reg       <= bx_next;
            by_reg       <= by_next;
            fx_reg       <= fx_next;
            fy_reg       <= fy_next;
            ex_reg       <= ex_next;
            ey_reg       <= ey_next;
            qx_reg       <= qx_next;
            qy_reg       <= qy_next;
            ady_reg      <= ady_next;
            doff_reg     <= doff_next;
            straddle_reg <= straddle_next;
            dpos_reg     <= dpos_next;
            prod_reg     <= prod_next;
            cross_reg    <= cross_next;
            dot_reg      <= dot_next;
            len_reg      <= len_next;
            num_reg      <= num_next;
            done_reg     <= done_next;
            location_reg <= location_next;
            overflow_reg <= overflow_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign location = location_reg;
    assign overflow = overflow_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pip_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int GAP_MAX = 6;
    localparam int RANDOM_ITEMS = 1650;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 800;
    localparam int COORD_MAX = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int COORD_MIN = -(2 ** (COORD_WIDTH - 1));
    localparam longint CROSS_SPAN = 64'sd2147483648;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    class pip_scoreboard;
        typedef struct packed {
            logic [1:0] location;
            logic       overflow;
        } answer_t;

        int vert_x[MAX_VERTICES];
        int vert_y[MAX_VERTICES];
        int n_vert;
        bit dropped;
        bit [TOL_WIDTH-1:0] tol;
        answer_t answers_q[$];
        int errors;
        int n_append;
        int n_dropped;
        int n_query;
        int n_loc[3];

        function bit on_edge(longint px, longint py, longint ax, longint ay,
                             longint bx, longint by, longint eps);
            longint ex, ey, qx, qy, cr, dt;
            ex = bx - ax;
            ey = by - ay;
            qx = px - ax;
            qy = py - ay;
            cr = ex * qy - ey * qx;
            if (cr > eps || cr < -eps)
                return 1'b0;
            dt = qx * ex + qy * ey;
            if (dt < -eps)
                return 1'b0;
            return dt <= ex * ex + ey * ey + eps;
        endfunction

        function logic [1:0] locate(longint px, longint py);
            longint eps, ix, iy, jx, jy, dy, num, d, ady, snum;
            bit odd;
            int j;
            eps = longint'({32'd0, tol});
            odd = 1'b0;
            for (int i = 0; i < n_vert; i++)
            begin
                j = (i + 1 == n_vert) ? 0 : i + 1;
                if (on_edge(px, py, vert_x[i], vert_y[i], vert_x[j], vert_y[j], eps))
                    return LOC_BOUNDARY;
            end
            j = n_vert - 1;
            for (int i = 0; i < n_vert; i++)
            begin
                ix = vert_x[i];
                iy = vert_y[i];
                jx = vert_x[j];
                jy = vert_y[j];
                if ((iy > py) != (jy > py))
                begin
                    dy = iy - jy;
                    num = (ix - jx) * (py - jy);
                    d = px - jx + eps;
                    ady = (dy > 0) ? dy : -dy;
                    snum = (dy > 0) ? num : -num;
                    if (d < CROSS_SPAN && d * ady < snum)
                        odd = !odd;
                end
                j = i;
            end
            return odd ? LOC_INSIDE : LOC_OUTSIDE;
        endfunction

        // called once per accepted transfer
        function void note_input(logic [1:0] act, coord_t x, coord_t y);
            answer_t a;
            case (act)
                ACT_CLEAR:
                begin
                    n_vert = 0;
                    dropped = 1'b0;
                end
                ACT_APPEND:
                begin
                    a.location = LOC_OUTSIDE;
                    a.overflow = 1'b0;
                    if (n_vert < MAX_VERTICES)
                    begin
                        vert_x[n_vert] = x;
                        vert_y[n_vert] = y;
                        n_vert++;
                    end
                    else
                    begin
                        dropped = 1'b1;
                        a.overflow = 1'b1;
                        n_dropped++;
                    end
                    n_append++;
                    answers_q = {answers_q, a};
                end
                ACT_QUERY:
                begin
                    a.location = locate(x, y);
                    a.overflow = dropped;
                    n_query++;
                    n_loc[a.location]++;
                    answers_q = {answers_q, a};
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [1:0] loc, logic ovf);
            answer_t a;
            if (answers_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending: location %0d overflow %0d",
                         $time, loc, ovf);
                return;
            end
            a = answers_q.pop_front();
            if (loc !== a.location)
            begin
                errors++;
                $display("%0t: location mismatch: expected %0d, actual %0d",
                         $time, a.location, loc);
            end
            if (ovf !== a.overflow)
            begin
                errors++;
                $display("%0t: overflow mismatch: expected %0d, actual %0d",
                         $time, a.overflow, ovf);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] action;
    coord_t coord_x;
    coord_t coord_y;
    logic tolerance_we;
    logic [TOL_WIDTH-1:0] tolerance;
    logic done;
    logic [1:0] location;
    logic overflow;

    pip_scoreboard sb = new();
    bit no_gap;
    int sent_items;
    int tol_writes;
    int phases;

    point_in_polygon_classify dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .tolerance_we (tolerance_we),
        .tolerance    (tolerance),
        .done         (done),
        .location     (location),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(location, overflow);
    end

    function automatic coord_t clamp_coord(int v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    function automatic coord_t rand_around(int c, int r);
        return clamp_coord(c + int'($urandom_range(0, 2 * r)) - r);
    endfunction

    function automatic coord_t rand_full();
        return coord_t'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(logic [1:0] act, coord_t x, coord_t y);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        action <= act;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(act, x, y);
        if (act != ACT_UNUSED)
            sent_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.answers_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_WIDTH-1:0] v);
        drain();
        tolerance_we <= 1'b1;
        tolerance <= v;
        @(negedge clk);
        tolerance_we <= 1'b0;
        sb.tol = v;
        tol_writes++;
    endtask

    task automatic polygon_phase(int phase_no);
        int n, m, k, scale, cx, cy, pick, a, b;
        int px[MAX_VERTICES + 8];
        int py[MAX_VERTICES + 8];
        coord_t qx, qy;
        case ($urandom_range(0, 2))
            0: scale = 20;
            1: scale = 2000;
            default: scale = 40000;
        endcase
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        pick = $urandom_range(0, 99);
        if (phase_no == 0)
            n = MAX_VERTICES + 3;
        else if (pick < 7)
            n = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
        else if (pick < 15)
            n = $urandom_range(1, 2);
        else
            n = $urandom_range(3, 10);
        no_gap = ($urandom_range(0, 3) == 0);

        // occasionally keep the old polygon and just keep appending
        if ($urandom_range(0, 9) != 0)
            send_item(ACT_CLEAR, rand_full(), rand_full());
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 15) == 0)
            begin
                px[i] = px[i - 1];
                py[i] = py[i - 1];
            end
            else
            begin
                px[i] = rand_around(cx, scale);
                py[i] = rand_around(cy, scale);
            end
            send_item(ACT_APPEND, coord_t'(px[i]), coord_t'(py[i]));
            if ($urandom_range(0, 29) == 0)
                send_item(ACT_UNUSED, rand_full(), rand_full());
        end

        m = (n < MAX_VERTICES) ? n : MAX_VERTICES;
        k = (n > 20) ? 2 : $urandom_range(4, 12);
        for (int q = 0; q < k; q++)
        begin
            a = $urandom_range(0, m - 1);
            b = (a + 1 == m) ? 0 : a + 1;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    qx = coord_t'(px[a]);
                    qy = coord_t'(py[a]);
                end
                3, 4:
                begin
                    qx = coord_t'((px[a] + px[b]) / 2);
                    qy = coord_t'((py[a] + py[b]) / 2);
                end
                5:
                begin
                    qx = rand_around(px[a], 1);
                    qy = rand_around(py[a], 1);
                end
                6, 7, 8:
                begin
                    qx = rand_around(cx, scale);
                    qy = rand_around(cy, scale);
                end
                default:
                begin
                    qx = rand_full();
                    qy = rand_full();
                end
            endcase
            send_item(ACT_QUERY, qx, qy);
            if ($urandom_range(0, 24) == 0)
                send_item(ACT_UNUSED, rand_full(), rand_full());
            if ($urandom_range(0, 39) == 0)
                send_item(ACT_CLEAR, rand_full(), rand_full());
        end
    endtask

    task automatic pick_tolerance(output logic [TOL_WIDTH-1:0] v);
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: v = '0;
            5: v = $urandom_range(0, 50);
            6: v = $urandom_range(0, 100000);
            7: v = 1;
            8: v = '1;
            9: v = $urandom();
            10: v = 32'h8000_0000;
            default: v = 32'h7fff_ffff;
        endcase
    endtask

    initial
    begin
        logic [TOL_WIDTH-1:0] tv;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_CLEAR;
        coord_x = '0;
        coord_y = '0;
        tolerance_we = 1'b0;
        tolerance = '0;
        no_gap = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        // empty polygon, then a single vertex acting as a zero-length edge
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_APPEND, 16'sd0, 16'sd0);
        send_item(ACT_QUERY, 16'sd5, 16'sd5);
        send_item(ACT_CLEAR, 16'sd0, 16'sd0);
        // triangle spanning the full coordinate range
        send_item(ACT_APPEND, coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        send_item(ACT_APPEND, coord_t'(COORD_MAX), coord_t'(COORD_MIN));
        send_item(ACT_APPEND, 16'sd0, coord_t'(COORD_MAX));
        send_item(ACT_QUERY, 16'sd0, 16'sd0);
        send_item(ACT_QUERY, coord_t'(COORD_MAX), coord_t'(COORD_MAX));
        send_item(ACT_QUERY, coord_t'(COORD_MIN), coord_t'(COORD_MIN));
        send_item(ACT_QUERY, 16'sd0, coord_t'(COORD_MIN));
        send_item(ACT_QUERY, coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        send_item(ACT_UNUSED, -16'sd1, -16'sd1);
        // repeated vertex closes a zero-length edge
        send_item(ACT_APPEND, 16'sd0, coord_t'(COORD_MAX));
        send_item(ACT_QUERY, 16'sd12345, -16'sd20000);
        send_item(ACT_CLEAR, -16'sd1, 16'sd1);
        write_tolerance('1);
        send_item(ACT_APPEND, 16'sd0, 16'sd0);
        send_item(ACT_APPEND, 16'sd10, 16'sd0);
        send_item(ACT_APPEND, 16'sd0, 16'sd10);
        send_item(ACT_QUERY, coord_t'(COORD_MIN), coord_t'(COORD_MAX));
        send_item(ACT_QUERY, 16'sd3, 16'sd3);
        write_tolerance('0);

        sent_items = 0;
        phases = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            if (phases > 0 && $urandom_range(0, 3) == 0)
            begin
                pick_tolerance(tv);
                write_tolerance(tv);
            end
            polygon_phase(phases);
            phases++;
        end

        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d appends (%0d dropped on a full store) and %0d queries",
                 sb.n_append, sb.n_dropped, sb.n_query);
        $display("answers: %0d outside, %0d boundary, %0d inside; %0d polygons, %0d tolerances",
                 sb.n_loc[LOC_OUTSIDE], sb.n_loc[LOC_BOUNDARY], sb.n_loc[LOC_INSIDE],
                 phases, tol_writes);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
